// ===== sv/dbsv_pkg.sv =====
// shared types, constants and the character classifier for the dot-bracket validator
// no dependencies; used by dbsv_scan and the top level
package dbsv_pkg;

    localparam int DEFAULT_MAX_LENGTH = 1024;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // characters that the structure string may hold
    localparam logic [7:0] CHAR_DOT          = 8'h2E;
    localparam logic [7:0] CHAR_UNDERSCORE   = 8'h5F;
    localparam logic [7:0] CHAR_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CHAR_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CHAR_OPEN_BRACE   = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE_BRACE  = 8'h7D;
    localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;

    // bracket kinds as held on the stack
    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_BRACE  = 2'd1;
    localparam logic [1:0] KIND_SQUARE = 2'd2;

    typedef enum logic [2:0] {
        ERR_OK            = 3'd0,
        ERR_TOO_LONG      = 3'd1,
        ERR_LEN_MISMATCH  = 3'd2,
        ERR_BAD_CHAR      = 3'd3,
        ERR_EXTRA_CLOSE   = 3'd4,
        ERR_TYPE_MISMATCH = 3'd5,
        ERR_UNCLOSED      = 3'd6
    } err_code_t;

    typedef enum logic [1:0] {
        BRK_NONE          = 2'd0,
        BRK_EXTRA_CLOSE   = 2'd1,
        BRK_TYPE_MISMATCH = 2'd2
    } brk_err_t;

    typedef struct packed {
        logic [7:0]  structure_char;
        logic [15:0] sequence_length;
        logic        is_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0] error_code;
        logic       is_valid;
    } out_item_t;

    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic       is_bad;
        logic [1:0] kind;
    } char_class_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r = '{is_open: 1'b0, is_close: 1'b0, is_bad: 1'b0, kind: KIND_PAREN};
        case (c)
            CHAR_OPEN_PAREN:   begin r.is_open  = 1'b1; r.kind = KIND_PAREN;  end
            CHAR_OPEN_BRACE:   begin r.is_open  = 1'b1; r.kind = KIND_BRACE;  end
            CHAR_OPEN_SQUARE:  begin r.is_open  = 1'b1; r.kind = KIND_SQUARE; end
            CHAR_CLOSE_PAREN:  begin r.is_close = 1'b1; r.kind = KIND_PAREN;  end
            CHAR_CLOSE_BRACE:  begin r.is_close = 1'b1; r.kind = KIND_BRACE;  end
            CHAR_CLOSE_SQUARE: begin r.is_close = 1'b1; r.kind = KIND_SQUARE; end
            CHAR_DOT, CHAR_UNDERSCORE: r.is_bad = 1'b0;
            default:           r.is_bad = 1'b1;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/dbsv_stack_ram.sv =====
// bracket-kind stack memory: one write port, one read port, registered read data
// no package dependency
module dbsv_stack_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rdata
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dbsv_scan.sv =====
// per-character scan: counters, sticky errors, stack pointer and top-of-stack tracking
// depends on dbsv_pkg and dbsv_stack_ram
module dbsv_scan #(
    parameter int MAX_LENGTH = dbsv_pkg::DEFAULT_MAX_LENGTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                acc,
    input  dbsv_pkg::in_item_t  item,
    output logic                res_valid,
    output dbsv_pkg::out_item_t res
);

    localparam int DW = $clog2(MAX_LENGTH + 1);
    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam logic [DW-1:0] DEPTH_FULL = DW'(MAX_LENGTH);
    localparam logic [15:0]   LEN_LIMIT  = 16'(MAX_LENGTH);

    logic [DW-1:0]       depth_reg, depth_next;
    logic [15:0]         count_reg, count_next;
    logic                bad_reg, bad_next;
    dbsv_pkg::brk_err_t  err_reg, err_next;
    logic [1:0]          tos_reg, tos_next;
    logic                tos_mem_reg, tos_mem_next;

    dbsv_pkg::char_class_t cls;
    dbsv_pkg::err_code_t   code;
    logic                  active;
    logic                  push;
    logic                  pop;
    logic [1:0]            top;
    logic [1:0]            rdata;
    logic                  mem_re;
    logic [DW-1:0]         below_top;

    assign cls       = dbsv_pkg::classify(item.structure_char);
    assign active    = (err_reg == dbsv_pkg::BRK_NONE);
    // top entry sits in a register after a push, in the ram output after a pop
    assign top       = tos_mem_reg ? rdata : tos_reg;
    assign push      = acc && active && cls.is_open && (depth_reg != DEPTH_FULL);
    assign pop       = acc && active && cls.is_close && (depth_reg != '0) && (top == cls.kind);
    assign below_top = depth_reg - DW'(2);
    assign mem_re    = pop && (depth_reg > DW'(1));

    dbsv_stack_ram #(
        .DEPTH (MAX_LENGTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (depth_reg[AW-1:0]),
        .wdata (cls.kind),
        .re    (mem_re),
        .raddr (below_top[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        logic [15:0]        cnt;
        logic               bad;
        dbsv_pkg::brk_err_t err;
        logic [DW-1:0]      dep;

        cnt = (count_reg != dbsv_pkg::COUNT_MAX) ? count_reg + 16'd1 : count_reg;
        bad = bad_reg | cls.is_bad;
        err = err_reg;
        dep = depth_reg;
        if (push)
        begin
            dep = depth_reg + DW'(1);
        end
        else if (pop)
        begin
            dep = depth_reg - DW'(1);
        end
        else if (active && cls.is_close)
        begin
            err = (depth_reg == '0) ? dbsv_pkg::BRK_EXTRA_CLOSE
                                    : dbsv_pkg::BRK_TYPE_MISMATCH;
        end

        if (cnt > LEN_LIMIT)
            code = dbsv_pkg::ERR_TOO_LONG;
        else if (cnt != item.sequence_length)
            code = dbsv_pkg::ERR_LEN_MISMATCH;
        else if (bad)
            code = dbsv_pkg::ERR_BAD_CHAR;
        else if (err == dbsv_pkg::BRK_EXTRA_CLOSE)
            code = dbsv_pkg::ERR_EXTRA_CLOSE;
        else if (err == dbsv_pkg::BRK_TYPE_MISMATCH)
            code = dbsv_pkg::ERR_TYPE_MISMATCH;
        else if (dep != '0)
            code = dbsv_pkg::ERR_UNCLOSED;
        else
            code = dbsv_pkg::ERR_OK;

        depth_next   = depth_reg;
        count_next   = count_reg;
        bad_next     = bad_reg;
        err_next     = err_reg;
        tos_next     = push ? cls.kind : tos_reg;
        tos_mem_next = push ? 1'b0 : (pop ? 1'b1 : tos_mem_reg);
        if (acc)
        begin
            if (item.is_last)
            begin
                // string done: back to the empty state
                depth_next = '0;
                count_next = '0;
                bad_next   = 1'b0;
                err_next   = dbsv_pkg::BRK_NONE;
            end
            else
            begin
                depth_next = dep;
                count_next = cnt;
                bad_next   = bad;
                err_next   = err;
            end
        end
    end

    assign res_valid      = acc && item.is_last;
    assign res.error_code = code;
    assign res.is_valid   = (code == dbsv_pkg::ERR_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= '0;
            count_reg   <= '0;
            bad_reg     <= 1'b0;
            err_reg     <= dbsv_pkg::BRK_NONE;
            tos_mem_reg <= 1'b0;
        end
        else
        begin
            depth_reg   <= depth_next;
            count_reg   <= count_next;
            bad_reg     <= bad_next;
            err_reg     <= err_next;
            tos_mem_reg <= tos_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_FULL)
        else $error("stack depth beyond limit");

    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && pop))
        else $error("push and pop in one cycle");

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (depth_reg == '0) && (count_reg == '0) && !bad_reg)
        else $error("state not cleared after result");

    a_sticky_error: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != dbsv_pkg::BRK_NONE) && !res_valid |=> err_reg == $past(err_reg))
        else $error("bracket error not held");

endmodule

// ===== sv/dot_bracket_structure_validator_unit.sv =====
// top level of the dot-bracket structure validator: input handshake and result register
// depends on dbsv_pkg and dbsv_scan (which holds dbsv_stack_ram)
//
// usage
//   in channel : one request per character (in_data.structure_char), with is_last marking
//                the final character; sequence_length is only looked at on that one
//   out channel: one request per string, issued for the last character; error_code gives
//                the highest-priority fault (0 ok .. 6 unclosed), is_valid is 1 for ok
//   throughput : one character per cycle when not stalled; each character does at most one
//                stack access, a push writing the ram or a pop reading the entry below the top
//   result     : the result appears in the output register in the cycle after the last
//                character is taken
//   stall      : a character is taken while the output register is empty or being
//                drained this cycle; a waiting result only holds up the input
//   reset      : asynchronous, clears counters, stack pointer and the output valid flag;
//                the stack ram is not cleared as entries are only read once written
//   strings are checked against MAX_LENGTH; opens beyond it are dropped
module dot_bracket_structure_validator_unit #(
    parameter int MAX_LENGTH = dbsv_pkg::DEFAULT_MAX_LENGTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dbsv_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dbsv_pkg::out_item_t out_data
);

    logic                acc;
    logic                res_valid;
    dbsv_pkg::out_item_t res;
    logic                out_valid_reg, out_valid_next;
    dbsv_pkg::out_item_t out_data_reg, out_data_next;

    // the output slot frees up in the same cycle it is taken
    assign in_ready = !out_valid_reg || out_ready;
    assign acc      = in_valid && in_ready;

    dbsv_scan #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .item      (in_data),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !out_valid_reg || out_ready)
        else $error("result overwrites a pending request");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> out_valid_reg)
        else $error("result not registered");

    a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.is_valid == (out_data_reg.error_code == dbsv_pkg::ERR_OK))
        else $error("is_valid disagrees with error_code");

endmodule
